// ===== design/crr_pkg.sv =====
// Shared types and constants for the cluster role rebalancer.
// Holds the channel structs, the stored node record, role codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
package crr_pkg;
	localparam int IdW = 64;
	localparam int DomW = 64;
	localparam int WtW = 16;
	localparam int TgtW = 5;
	localparam int CfgW = 64;
	localparam int CfgIdxW = 2;
	localparam int ResLimit = 64;
	localparam int ResCntW = 7;

	localparam logic [1:0] ROLE_VOTER = 2'd0;
	localparam logic [1:0] ROLE_STANDBY = 2'd1;
	localparam logic [1:0] ROLE_SPARE = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_TARGET_VOTERS = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_TARGET_STANDBYS = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_OWN_ID = 2'd2;

	typedef struct packed {
		logic [IdW-1:0] node_id;
		logic online;
		logic [1:0] role;
		logic [DomW-1:0] fault_zone;
		logic [WtW-1:0] weight;
		logic last_node;
	} rec_t;

	typedef struct packed {
		logic [IdW-1:0] changed_id;
		logic [1:0] new_role;
		logic has_change;
		logic last_change;
	} chg_t;

	typedef struct packed {
		logic [IdW-1:0] node_id;
		logic online;
		logic [1:0] role;
		logic [DomW-1:0] fault_zone;
		logic [WtW-1:0] weight;
	} node_t;
endpackage

// ===== design/crr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module crr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port, then registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/cluster_role_rebalancer.sv =====
// Cluster role rebalancer top level.
// Depends on crr_pkg and crr_ram (node record table).
`timescale 1ns / 1ps
// Usage:
// Node records arrive on the rec channel (rec_valid / rec_stall / rec), one per
// cycle while the block is loading. Records beyond MAX_NODES are dropped.
// A record with last_node set starts a run: the block raises rec_stall and
// walks the record table in its RAM, one read per entry. Pass one demotes
// offline nodes and tallies domains. Each of the four rebalancing passes
// whose target is unmet runs a key sweep, a ranking step through one shared
// comparator, a step to build the order and a read-modify-write walk over
// the table that stops once the target is met.
// Role changes leave on the chg channel (chg_valid / chg_stall / chg); the
// last one of a run carries last_change, and a run with no change gives a
// single transaction with has_change low. A stalled receiver holds the run.
// Registers are written through cfg_we / cfg_idx / cfg_data while idle.
// Reset restores the register defaults and empties the record table.
module cluster_role_rebalancer #(
	parameter int MAX_NODES = 16,
	parameter int DOMAIN_SLOTS = 5,
	parameter int WEIGHT_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	output logic rec_stall,
	input  crr_pkg::rec_t rec,
	output logic chg_valid,
	input  logic chg_stall,
	output crr_pkg::chg_t chg,
	input  logic cfg_we,
	input  logic [crr_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [crr_pkg::CfgW-1:0] cfg_data
);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = (NW > crr_pkg::TgtW) ? NW : crr_pkg::TgtW;
	localparam int SW = $clog2(DOMAIN_SLOTS + 1);
	localparam int SIW = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
	localparam int KW = NW + crr_pkg::WtW + 2;
	localparam int RW = $bits(crr_pkg::node_t);
	localparam logic [crr_pkg::WtW-1:0] WMASK = (WEIGHT_BITS >= crr_pkg::WtW) ?
		{crr_pkg::WtW{1'b1}} : crr_pkg::WtW'((64'd1 << WEIGHT_BITS) - 64'd1);

	typedef enum logic [10:0] {
		S_LOAD = 11'b00000000001,
		S_P1R  = 11'b00000000010,
		S_P1X  = 11'b00000000100,
		S_DEC  = 11'b00000001000,
		S_KR   = 11'b00000010000,
		S_KX   = 11'b00000100000,
		S_RANK = 11'b00001000000,
		S_PERM = 11'b00010000000,
		S_LR   = 11'b00100000000,
		S_LX   = 11'b01000000000,
		S_FL   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [crr_pkg::TgtW-1:0] tv_q, ts_q;
	logic [crr_pkg::IdW-1:0] own_q;
	logic [NW-1:0] cnt_q, n_q, i_q, rj_q, rk_q;
	logic [AW-1:0] acc_q, x_q;
	logic [1:0] ph_q;
	logic [CW-1:0] vt_q, st_q;
	logic [SW-1:0] vused_q, sused_q;
	logic [crr_pkg::DomW-1:0] vkey_q [DOMAIN_SLOTS];
	logic [crr_pkg::DomW-1:0] skey_q [DOMAIN_SLOTS];
	logic [NW-1:0] vcnt_q [DOMAIN_SLOTS];
	logic [NW-1:0] scnt_q [DOMAIN_SLOTS];
	logic [KW-1:0] key_q [MAX_NODES];
	logic [AW-1:0] pos_q [MAX_NODES];
	logic [AW-1:0] npos_q [MAX_NODES];
	logic [AW-1:0] perm_q [MAX_NODES];
	logic [crr_pkg::ResCntW-1:0] k_q;
	logic pend_v_q;
	crr_pkg::chg_t pend_q;
	logic out_v_q;
	crr_pkg::chg_t out_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	crr_pkg::node_t rd, ld;

	logic vh, sh;
	logic [SIW-1:0] vi, si;
	logic [NW-1:0] lk_cnt;
	logic cond, act, out_free, stay, less, rec_acc;
	logic [1:0] act_role;
	logic [KW-1:0] kj, kk;

	assign rec_stall = (state_q != S_LOAD);
	assign rec_acc = rec_valid && !rec_stall;
	assign chg_valid = out_v_q;
	assign chg = out_q;
	assign out_free = !out_v_q || !chg_stall;
	assign rd = crr_pkg::node_t'(ram_rdata);

	// record written on load, masked weight
	always_comb begin
		ld.node_id = rec.node_id;
		ld.online = rec.online;
		ld.role = rec.role;
		ld.fault_zone = rec.fault_zone;
		ld.weight = rec.weight & WMASK;
	end

	// RAM port steering
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = RW'(ld);
		ram_re = 1'b0;
		ram_raddr = i_q[AW-1:0];
		if (state_q == S_LOAD) begin
			ram_we = rec_acc && (cnt_q < NW'(MAX_NODES));
		end else if (state_q == S_P1R || state_q == S_KR) begin
			ram_re = 1'b1;
		end else if (state_q == S_LR) begin
			ram_re = 1'b1;
			ram_raddr = perm_q[i_q[AW-1:0]];
		end else if (state_q == S_P1X) begin
			ram_we = act && !stay;
			ram_waddr = i_q[AW-1:0];
			ram_wdata = {rd.node_id, rd.online, crr_pkg::ROLE_SPARE, rd.fault_zone,
				rd.weight};
		end else if (state_q == S_LX) begin
			ram_we = act && !stay;
			ram_waddr = x_q;
			ram_wdata = {rd.node_id, rd.online, act_role, rd.fault_zone, rd.weight};
		end
	end

	crr_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_nodes (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
	);

	// domain slot lookup, first match among used slots
	always_comb begin
		vh = 1'b0;
		vi = '0;
		sh = 1'b0;
		si = '0;
		for (int s = DOMAIN_SLOTS - 1; s >= 0; s--) begin
			if (SW'(s) < vused_q && vkey_q[s] == rd.fault_zone) begin
				vh = 1'b1;
				vi = SIW'(s);
			end
			if (SW'(s) < sused_q && skey_q[s] == rd.fault_zone) begin
				sh = 1'b1;
				si = SIW'(s);
			end
		end
		if (!ph_q[1]) begin
			lk_cnt = vh ? vcnt_q[vi] : '0;
		end else begin
			lk_cnt = sh ? scnt_q[si] : '0;
		end
	end

	// pass target condition and per-pass action
	always_comb begin
		unique case (ph_q)
			2'd0: cond = vt_q < CW'(tv_q);
			2'd1: cond = vt_q > CW'(tv_q);
			2'd2: cond = st_q < CW'(ts_q);
			default: cond = st_q > CW'(ts_q);
		endcase
		act = 1'b0;
		act_role = crr_pkg::ROLE_SPARE;
		if (state_q == S_P1X) begin
			act = !rd.online && rd.role != crr_pkg::ROLE_SPARE;
		end else begin
			unique case (ph_q)
				2'd0: begin
					act = rd.online && rd.role != crr_pkg::ROLE_VOTER;
					act_role = crr_pkg::ROLE_VOTER;
				end
				2'd1: act = rd.role == crr_pkg::ROLE_VOTER && rd.node_id != own_q;
				2'd2: begin
					act = rd.online && rd.role == crr_pkg::ROLE_SPARE;
					act_role = crr_pkg::ROLE_STANDBY;
				end
				default: act = rd.role == crr_pkg::ROLE_STANDBY;
			endcase
		end
		stay = act && (k_q < crr_pkg::ResCntW'(crr_pkg::ResLimit)) && pend_v_q && !out_free;
	end

	// ranking comparator: does entry rk precede entry rj
	always_comb begin
		kj = key_q[rj_q[AW-1:0]];
		kk = key_q[rk_q[AW-1:0]];
		if (kk != kj) begin
			less = ph_q[0] ? (kk > kj) : (kk < kj);
		end else begin
			less = pos_q[rk_q[AW-1:0]] < pos_q[rj_q[AW-1:0]];
		end
	end

	// sequencer, tallies and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			tv_q <= crr_pkg::TgtW'(3);
			ts_q <= crr_pkg::TgtW'(3);
			own_q <= '0;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			rj_q <= '0;
			rk_q <= '0;
			acc_q <= '0;
			ph_q <= '0;
			vt_q <= '0;
			st_q <= '0;
			vused_q <= '0;
			sused_q <= '0;
			k_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int s = 0; s < DOMAIN_SLOTS; s++) begin
				vcnt_q[s] <= '0;
				scnt_q[s] <= '0;
			end
		end else begin
			// drop a taken transaction
			if (out_v_q && !chg_stall) begin
				out_v_q <= 1'b0;
			end
			// stage an emitted change, pushing the older one out
			if ((state_q == S_P1X || state_q == S_LX) && act && !stay &&
				k_q < crr_pkg::ResCntW'(crr_pkg::ResLimit)) begin
				if (pend_v_q) begin
					out_q <= pend_q;
					out_v_q <= 1'b1;
				end
				pend_q <= '{changed_id: rd.node_id, new_role: act_role,
					has_change: 1'b1, last_change: 1'b0};
				pend_v_q <= 1'b1;
				k_q <= k_q + 1'b1;
			end
			unique case (state_q)
				S_LOAD: begin
					if (cfg_we) begin
						unique case (cfg_idx)
							crr_pkg::REG_TARGET_VOTERS: tv_q <= cfg_data[crr_pkg::TgtW-1:0];
							crr_pkg::REG_TARGET_STANDBYS: ts_q <= cfg_data[crr_pkg::TgtW-1:0];
							crr_pkg::REG_OWN_ID: own_q <= cfg_data;
							default: ;
						endcase
					end
					if (rec_acc) begin
						if (cnt_q < NW'(MAX_NODES)) begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (rec.last_node) begin
							n_q <= (cnt_q < NW'(MAX_NODES)) ? cnt_q + 1'b1 : cnt_q;
							i_q <= '0;
							vt_q <= '0;
							st_q <= '0;
							vused_q <= '0;
							sused_q <= '0;
							k_q <= '0;
							pend_v_q <= 1'b0;
							for (int s = 0; s < DOMAIN_SLOTS; s++) begin
								vcnt_q[s] <= '0;
								scnt_q[s] <= '0;
							end
							for (int j = 0; j < MAX_NODES; j++) begin
								pos_q[j] <= AW'(j);
							end
							state_q <= S_P1R;
						end
					end
				end
				S_P1R: state_q <= S_P1X;
				S_P1X: begin
					if (!stay) begin
						if (!act && rd.online && rd.role == crr_pkg::ROLE_VOTER) begin
							vt_q <= vt_q + 1'b1;
							if (vh) begin
								vcnt_q[vi] <= vcnt_q[vi] + 1'b1;
							end else if (vused_q < SW'(DOMAIN_SLOTS)) begin
								vkey_q[vused_q[SIW-1:0]] <= rd.fault_zone;
								vcnt_q[vused_q[SIW-1:0]] <= NW'(1);
								vused_q <= vused_q + 1'b1;
							end
						end else if (!act && rd.online && rd.role == crr_pkg::ROLE_STANDBY) begin
							st_q <= st_q + 1'b1;
							if (sh) begin
								scnt_q[si] <= scnt_q[si] + 1'b1;
							end else if (sused_q < SW'(DOMAIN_SLOTS)) begin
								skey_q[sused_q[SIW-1:0]] <= rd.fault_zone;
								scnt_q[sused_q[SIW-1:0]] <= NW'(1);
								sused_q <= sused_q + 1'b1;
							end
						end
						if (i_q + 1'b1 == n_q) begin
							ph_q <= '0;
							state_q <= S_DEC;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_P1R;
						end
					end
				end
				S_DEC: begin
					i_q <= '0;
					if (cond) begin
						state_q <= S_KR;
					end else if (ph_q == 2'd3) begin
						state_q <= S_FL;
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_KR: state_q <= S_KX;
				S_KX: begin
					key_q[i_q[AW-1:0]] <= {lk_cnt, rd.weight, rd.role};
					if (i_q + 1'b1 == n_q) begin
						rj_q <= '0;
						rk_q <= '0;
						acc_q <= '0;
						state_q <= S_RANK;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_KR;
					end
				end
				S_RANK: begin
					if (rk_q + 1'b1 == n_q) begin
						npos_q[rj_q[AW-1:0]] <= acc_q + AW'(less);
						acc_q <= '0;
						rk_q <= '0;
						rj_q <= rj_q + 1'b1;
						if (rj_q + 1'b1 == n_q) begin
							state_q <= S_PERM;
						end
					end else begin
						acc_q <= acc_q + AW'(less);
						rk_q <= rk_q + 1'b1;
					end
				end
				S_PERM: begin
					for (int j = 0; j < MAX_NODES; j++) begin
						pos_q[j] <= npos_q[j];
						if (NW'(j) < n_q) begin
							perm_q[npos_q[j]] <= AW'(j);
						end
					end
					i_q <= '0;
					state_q <= S_LR;
				end
				S_LR: begin
					if (i_q == n_q || !cond) begin
						if (ph_q == 2'd3) begin
							state_q <= S_FL;
						end else begin
							ph_q <= ph_q + 1'b1;
							state_q <= S_DEC;
						end
					end else begin
						x_q <= perm_q[i_q[AW-1:0]];
						state_q <= S_LX;
					end
				end
				S_LX: begin
					if (!stay) begin
						if (act) begin
							unique case (ph_q)
								2'd0: begin
									if (rd.role == crr_pkg::ROLE_STANDBY) begin
										if (st_q != '0) begin
											st_q <= st_q - 1'b1;
										end
										if (sh && scnt_q[si] != '0) begin
											scnt_q[si] <= scnt_q[si] - 1'b1;
										end
									end
									vt_q <= vt_q + 1'b1;
									if (vh) begin
										vcnt_q[vi] <= vcnt_q[vi] + 1'b1;
									end else if (vused_q < SW'(DOMAIN_SLOTS)) begin
										vkey_q[vused_q[SIW-1:0]] <= rd.fault_zone;
										vcnt_q[vused_q[SIW-1:0]] <= NW'(1);
										vused_q <= vused_q + 1'b1;
									end
								end
								2'd1: begin
									vt_q <= vt_q - 1'b1;
									if (vh && vcnt_q[vi] != '0) begin
										vcnt_q[vi] <= vcnt_q[vi] - 1'b1;
									end
								end
								2'd2: begin
									st_q <= st_q + 1'b1;
									if (sh) begin
										scnt_q[si] <= scnt_q[si] + 1'b1;
									end else if (sused_q < SW'(DOMAIN_SLOTS)) begin
										skey_q[sused_q[SIW-1:0]] <= rd.fault_zone;
										scnt_q[sused_q[SIW-1:0]] <= NW'(1);
										sused_q <= sused_q + 1'b1;
									end
								end
								default: begin
									st_q <= st_q - 1'b1;
									if (sh && scnt_q[si] != '0) begin
										scnt_q[si] <= scnt_q[si] - 1'b1;
									end
								end
							endcase
						end
						i_q <= i_q + 1'b1;
						state_q <= S_LR;
					end
				end
				S_FL: begin
					// close the run: mark the final change, or report an empty run
					if (out_free) begin
						out_v_q <= 1'b1;
						if (pend_v_q) begin
							out_q <= '{changed_id: pend_q.changed_id, new_role: pend_q.new_role,
								has_change: 1'b1, last_change: 1'b1};
						end else begin
							out_q <= '{changed_id: '0, new_role: crr_pkg::ROLE_VOTER,
								has_change: 1'b0, last_change: 1'b1};
						end
						pend_v_q <= 1'b0;
						cnt_q <= '0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
